// ----- rtl/bscp_pkg.sv -----
// Shared types, constants and helpers of the beam search candidate pool.
// No dependencies; every other file of the block imports this package.
package bscp_pkg;

    localparam int DEF_POOL_DEPTH = 64;
    localparam int DEF_POINT_BITS = 24;
    localparam int DIST_W         = 32;
    localparam int CFG_W          = 7;
    localparam int KIND_W         = 2;

    localparam logic [CFG_W-1:0] POOL_LIMIT_RST   = 7'd64;
    localparam logic [CFG_W-1:0] RESULT_COUNT_RST = 7'd10;

    typedef enum logic [KIND_W-1:0] {
        KIND_CLEAR  = 2'd0,
        KIND_INSERT = 2'd1,
        KIND_TAKE   = 2'd2,
        KIND_READ   = 2'd3
    } kind_t;

    typedef enum logic {
        REG_POOL_LIMIT   = 1'b0,
        REG_RESULT_COUNT = 1'b1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TAKE,
        ST_READ
    } state_t;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_CLEAR,
        CELL_INSERT,
        CELL_SEL_LOAD,
        CELL_SEL_SHIFT,
        CELL_MARK
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     full;   // pool at its limit: only occupied cells may move
    } cell_ctl_t;

    // 0 acts as 1, anything above the depth acts as the depth
    function automatic logic [CFG_W-1:0] clamp_cfg(input logic [CFG_W-1:0] v,
                                                   input logic [CFG_W-1:0] depth);
        logic [CFG_W-1:0] r;
        r = v;
        if (v == '0)
            r = {{(CFG_W-1){1'b0}}, 1'b1};
        else if (v > depth)
            r = depth;
        return r;
    endfunction

endpackage

// ----- rtl/bscp_cell.sv -----
// One slot of the sorted candidate pool: entry, checked mark, select token.
// Depends on bscp_pkg; instantiated in a row by beam_search_candidate_pool.
module bscp_cell #(
    parameter int POINT_BITS = bscp_pkg::DEF_POINT_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  bscp_pkg::cell_ctl_t           ctl,
    input  logic [POINT_BITS-1:0]         cand_point,
    input  logic [bscp_pkg::DIST_W-1:0]   cand_distance,
    input  logic                          sel_load,
    input  logic [POINT_BITS-1:0]         left_point,
    input  logic [bscp_pkg::DIST_W-1:0]   left_distance,
    input  logic                          left_valid,
    input  logic                          left_checked,
    input  logic                          left_less,
    input  logic                          left_sel,
    output logic [POINT_BITS-1:0]         point,
    output logic [bscp_pkg::DIST_W-1:0]   distance,
    output logic                          valid,
    output logic                          checked,
    output logic                          less,
    output logic                          sel,
    output logic                          lt_valid
);
    import bscp_pkg::*;

    logic [POINT_BITS-1:0] point_reg, point_next;
    logic [DIST_W-1:0]     distance_reg, distance_next;
    logic                  valid_reg, valid_next;
    logic                  checked_reg, checked_next;
    logic                  sel_reg, sel_next;
    logic                  lt;
    logic                  upd;

    // key order: distance, then lower point index
    assign lt       = {cand_distance, cand_point} < {distance_reg, point_reg};
    assign less     = !valid_reg || lt;
    assign lt_valid = valid_reg && lt;
    assign upd      = (ctl.op == CELL_INSERT) && less && (!ctl.full || valid_reg);

    always_comb
    begin
        point_next    = point_reg;
        distance_next = distance_reg;
        valid_next    = valid_reg;
        checked_next  = checked_reg;
        sel_next      = sel_reg;
        case (ctl.op)
            CELL_CLEAR:
            begin
                valid_next   = 1'b0;
                checked_next = 1'b0;
            end
            CELL_INSERT:
            begin
                if (upd)
                begin
                    // shift right behind the new entry, or take it here
                    if (left_less)
                    begin
                        point_next    = left_point;
                        distance_next = left_distance;
                        valid_next    = left_valid;
                        checked_next  = left_checked;
                    end
                    else
                    begin
                        point_next    = cand_point;
                        distance_next = cand_distance;
                        valid_next    = 1'b1;
                        checked_next  = 1'b0;
                    end
                end
            end
            CELL_SEL_LOAD:  sel_next = sel_load;
            CELL_SEL_SHIFT: sel_next = left_sel;
            CELL_MARK:
            begin
                checked_next = checked_reg | sel_reg;
                sel_next     = 1'b0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= 1'b0;
            checked_reg <= 1'b0;
            sel_reg     <= 1'b0;
        end
        else
        begin
            valid_reg   <= valid_next;
            checked_reg <= checked_next;
            sel_reg     <= sel_next;
        end
    end

    always_ff @(posedge clk)
    begin
        point_reg    <= point_next;
        distance_reg <= distance_next;
    end

    assign point    = point_reg;
    assign distance = distance_reg;
    assign valid    = valid_reg;
    assign checked  = checked_reg;
    assign sel      = sel_reg;

endmodule

// ----- rtl/beam_search_candidate_pool.sv -----
// Top level of the beam search candidate pool: request channel, result
// channel, configuration registers, control sequencer and the row of cells.
// Depends on bscp_pkg and bscp_cell.
//
// Usage
//   Requests enter on s_tvalid/s_tready; s_tuser carries the kind (clear,
//   insert, take best unchecked, read out), s_tdata the candidate point and
//   distance. Results leave on m_tvalid/m_tready, one per request, or
//   result_count of them for a readout, the final one flagged by m_tlast.
//   Configuration (pool_limit, result_count) must be written through cfg_we /
//   cfg_addr / cfg_wdata while no request is in flight; the block does not enforce it.
// Timing
//   Clear and insert finish in the accept cycle; the result is valid in the
//   next cycle. Take does a find-first select, then reads and marks. Readout
//   gives one rank per cycle while the receiver does not stall, as the select
//   token steps down the row of cells. One request is worked on at a time.
// Reset and stall
//   Reset empties the pool and sets pool_limit 64, result_count 10. When the
//   receiver stalls, the result waits in the output register and s_tready
//   stays low until that register can be refilled.
module beam_search_candidate_pool #(
    parameter int POOL_DEPTH = bscp_pkg::DEF_POOL_DEPTH,
    parameter int POINT_BITS = bscp_pkg::DEF_POINT_BITS,
    parameter int TDATA_W    = ((POINT_BITS + bscp_pkg::DIST_W + 7) / 8) * 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // request channel
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [TDATA_W-1:0]            s_tdata,   // cand_point, cand_distance, zero pad
    input  logic [bscp_pkg::KIND_W-1:0]   s_tuser,   // kind
    // result channel
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [TDATA_W-1:0]            m_tdata,   // entry_point, entry_distance, zero pad
    output logic [bscp_pkg::KIND_W:0]     m_tuser,   // echo_kind, hit
    output logic                          m_tlast,   // last_of_run
    // configuration
    input  logic                          cfg_we,
    input  bscp_pkg::cfg_reg_t            cfg_addr,
    input  logic [bscp_pkg::CFG_W-1:0]    cfg_wdata
);
    import bscp_pkg::*;

    localparam int FILL_W = $clog2(POOL_DEPTH + 1);
    localparam int RANK_W = $clog2(POOL_DEPTH);
    localparam logic [CFG_W-1:0] DEPTH_CFG = CFG_W'(POOL_DEPTH);

    // configuration
    logic [CFG_W-1:0] pool_limit_reg;
    logic [CFG_W-1:0] result_count_reg;
    logic [CFG_W-1:0] lim_eff;
    logic [CFG_W-1:0] read_n;

    // control
    state_t            state_reg, state_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [RANK_W-1:0] cnt_reg, cnt_next;
    logic              full;
    logic              s_acc;
    logic              out_free;
    logic              read_last;
    logic              ins_ok;
    cell_ctl_t         ctl;
    logic [POOL_DEPTH-1:0] sel_load_vec;

    // request fields
    kind_t                 in_kind;
    logic [POINT_BITS-1:0] in_point;
    logic [DIST_W-1:0]     in_dist;

    // cell row
    logic [POINT_BITS-1:0] c_point    [POOL_DEPTH];
    logic [DIST_W-1:0]     c_distance [POOL_DEPTH];
    logic [POINT_BITS-1:0] l_point    [POOL_DEPTH];
    logic [DIST_W-1:0]     l_distance [POOL_DEPTH];
    logic [POOL_DEPTH-1:0] c_valid, c_checked, c_less, c_sel, c_lt_valid;
    logic [POOL_DEPTH-1:0] l_valid, l_checked, l_less, l_sel;
    logic [POOL_DEPTH-1:0] avail_vec, first_vec;

    // selected entry
    logic [POINT_BITS-1:0] pick_point;
    logic [DIST_W-1:0]     pick_dist;
    logic                  pick_hit;

    // output register
    logic                  m_tvalid_reg, m_tvalid_next;
    logic                  out_load;
    kind_t                 out_kind_reg, out_kind_next;
    logic [POINT_BITS-1:0] out_point_reg, out_point_next;
    logic [DIST_W-1:0]     out_dist_reg, out_dist_next;
    logic                  out_hit_reg, out_hit_next;
    logic                  out_last_reg, out_last_next;

    assign in_kind  = kind_t'(s_tuser);
    assign in_point = s_tdata[POINT_BITS-1:0];
    assign in_dist  = s_tdata[POINT_BITS +: DIST_W];

    assign lim_eff = clamp_cfg(pool_limit_reg, DEPTH_CFG);
    assign read_n  = clamp_cfg(result_count_reg, DEPTH_CFG);
    // a lowered limit below the fill still counts as full
    assign full    = CFG_W'(fill_reg) >= lim_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_limit_reg   <= POOL_LIMIT_RST;
            result_count_reg <= RESULT_COUNT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_POOL_LIMIT:   pool_limit_reg   <= cfg_wdata;
                REG_RESULT_COUNT: result_count_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // row of cells; each one sees its left neighbor, cell 0 sees nothing
    genvar gi;
    generate
        for (gi = 0; gi < POOL_DEPTH; gi++)
        begin : g_cell
            if (gi == 0)
            begin : g_head
                assign l_point[gi]    = '0;
                assign l_distance[gi] = '0;
                assign l_valid[gi]    = 1'b0;
                assign l_checked[gi]  = 1'b0;
                assign l_less[gi]     = 1'b0;
                assign l_sel[gi]      = 1'b0;
            end
            else
            begin : g_link
                assign l_point[gi]    = c_point[gi-1];
                assign l_distance[gi] = c_distance[gi-1];
                assign l_valid[gi]    = c_valid[gi-1];
                assign l_checked[gi]  = c_checked[gi-1];
                assign l_less[gi]     = c_less[gi-1];
                assign l_sel[gi]      = c_sel[gi-1];
            end

            bscp_cell #(
                .POINT_BITS (POINT_BITS)
            ) u_cell (
                .clk           (clk),
                .rst_n         (rst_n),
                .ctl           (ctl),
                .cand_point    (in_point),
                .cand_distance (in_dist),
                .sel_load      (sel_load_vec[gi]),
                .left_point    (l_point[gi]),
                .left_distance (l_distance[gi]),
                .left_valid    (l_valid[gi]),
                .left_checked  (l_checked[gi]),
                .left_less     (l_less[gi]),
                .left_sel      (l_sel[gi]),
                .point         (c_point[gi]),
                .distance      (c_distance[gi]),
                .valid         (c_valid[gi]),
                .checked       (c_checked[gi]),
                .less          (c_less[gi]),
                .sel           (c_sel[gi]),
                .lt_valid      (c_lt_valid[gi])
            );
        end
    endgenerate

    // best unchecked entry: lowest set bit of the available mask
    assign avail_vec = c_valid & ~c_checked;
    assign first_vec = avail_vec & (~avail_vec + 1'b1);

    // when full, the row is sorted, so any occupied cell above the candidate
    // means the last one is above it too
    assign ins_ok = !full || (|c_lt_valid);

    // AND-OR read of the cell holding the select token
    always_comb
    begin
        pick_point = '0;
        pick_dist  = '0;
        for (int i = 0; i < POOL_DEPTH; i++)
        begin
            if (c_sel[i] && c_valid[i])
            begin
                pick_point = pick_point | c_point[i];
                pick_dist  = pick_dist | c_distance[i];
            end
        end
    end
    assign pick_hit = |(c_sel & c_valid);

    assign out_free  = !m_tvalid_reg || m_tready;
    assign s_tready  = (state_reg == ST_IDLE) && out_free;
    assign s_acc     = s_tvalid && s_tready;
    assign read_last = (CFG_W'(cnt_reg) + 1'b1) == read_n;

    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        cnt_next       = cnt_reg;
        ctl.op         = CELL_HOLD;
        ctl.full       = full;
        sel_load_vec   = '0;
        out_load       = 1'b0;
        out_kind_next  = out_kind_reg;
        out_point_next = '0;
        out_dist_next  = '0;
        out_hit_next   = 1'b0;
        out_last_next  = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_acc)
                begin
                    out_kind_next = in_kind;
                    case (in_kind)
                        KIND_CLEAR:
                        begin
                            ctl.op    = CELL_CLEAR;
                            fill_next = '0;
                            out_load  = 1'b1;
                        end
                        KIND_INSERT:
                        begin
                            ctl.op       = CELL_INSERT;
                            out_load     = 1'b1;
                            out_hit_next = ins_ok;
                            if (!full)
                                fill_next = fill_reg + 1'b1;
                        end
                        KIND_TAKE:
                        begin
                            ctl.op       = CELL_SEL_LOAD;
                            sel_load_vec = first_vec;
                            state_next   = ST_TAKE;
                        end
                        KIND_READ:
                        begin
                            ctl.op       = CELL_SEL_LOAD;
                            sel_load_vec = POOL_DEPTH'(1);
                            cnt_next     = '0;
                            state_next   = ST_READ;
                        end
                        default: ;
                    endcase
                end
            end
            ST_TAKE:
            begin
                if (out_free)
                begin
                    ctl.op         = CELL_MARK;
                    out_load       = 1'b1;
                    out_point_next = pick_point;
                    out_dist_next  = pick_dist;
                    out_hit_next   = pick_hit;
                    state_next     = ST_IDLE;
                end
            end
            ST_READ:
            begin
                if (out_free)
                begin
                    ctl.op         = CELL_SEL_SHIFT;
                    out_load       = 1'b1;
                    out_point_next = pick_point;
                    out_dist_next  = pick_dist;
                    out_hit_next   = pick_hit;
                    out_last_next  = read_last;
                    cnt_next       = cnt_reg + 1'b1;
                    if (read_last)
                        state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign m_tvalid_next = out_load ? 1'b1 : (m_tready ? 1'b0 : m_tvalid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            fill_reg     <= '0;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            fill_reg     <= fill_next;
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        // kind is latched at accept so take and readout results echo it
        if (out_load || s_acc)
            out_kind_reg <= out_kind_next;
        if (out_load)
        begin
            out_point_reg <= out_point_next;
            out_dist_reg  <= out_dist_next;
            out_hit_reg   <= out_hit_next;
            out_last_reg  <= out_last_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = TDATA_W'({out_dist_reg, out_point_reg});
    assign m_tuser  = {out_hit_reg, out_kind_reg};
    assign m_tlast  = out_last_reg;

endmodule

// ----- rtl/bscp_checker.sv -----
// Port-level checks of beam_search_candidate_pool, bound to the top level.
// Depends on bscp_pkg.
module bscp_checker #(
    parameter int POINT_BITS = bscp_pkg::DEF_POINT_BITS,
    parameter int TDATA_W    = ((POINT_BITS + bscp_pkg::DIST_W + 7) / 8) * 8
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [bscp_pkg::KIND_W-1:0]   s_tuser,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [TDATA_W-1:0]            m_tdata,
    input logic [bscp_pkg::KIND_W:0]     m_tuser
);
    import bscp_pkg::*;

    // clear and insert answer in the cycle after the request, as a lone result
    a_quick_result: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready &&
         (s_tuser == KIND_CLEAR || s_tuser == KIND_INSERT))
        |=> (m_tvalid && m_tuser[KIND_W-1:0] == $past(s_tuser)))
        else $error("clear/insert result missing or wrong kind");

    // a miss never carries an entry
    a_miss_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser[KIND_W]) |-> (m_tdata == '0))
        else $error("miss result carries entry data");

    // clear never reports a hit
    a_clear_nohit: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[KIND_W-1:0] == KIND_CLEAR) |-> !m_tuser[KIND_W])
        else $error("clear result with hit set");

    // stalled result holds
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed");

endmodule

bind beam_search_candidate_pool bscp_checker #(
    .POINT_BITS (POINT_BITS),
    .TDATA_W    (TDATA_W)
) u_bscp_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ----- tb/bscp_checker.sv -----
`timescale 1ns / 100ps
// Scoreboard for the beam search candidate pool: snoops request, result and
// config ports, predicts every result and compares it. Uses bscp_pkg.
module bscp_scoreboard #(
    parameter int POOL_DEPTH = bscp_pkg::DEF_POOL_DEPTH,
    parameter int POINT_BITS = bscp_pkg::DEF_POINT_BITS,
    parameter int TDATA_W    = ((POINT_BITS + bscp_pkg::DIST_W + 7) / 8) * 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [TDATA_W-1:0]            s_tdata,    // cand_point, cand_distance, zero pad
    input  logic [bscp_pkg::KIND_W-1:0]   s_tuser,    // kind
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [TDATA_W-1:0]            m_tdata,    // entry_point, entry_distance, zero pad
    input  logic [bscp_pkg::KIND_W:0]     m_tuser,    // echo_kind, hit
    input  logic                          m_tlast,    // last_of_run
    input  logic                          cfg_we,
    input  bscp_pkg::cfg_reg_t            cfg_addr,
    input  logic [bscp_pkg::CFG_W-1:0]    cfg_wdata,
    output int                            outstanding,
    output int                            mismatches
);
    import bscp_pkg::*;

    typedef struct packed {
        kind_t                 kind;
        logic [POINT_BITS-1:0] point;
        logic [DIST_W-1:0]     distance;
        logic                  hit;
        logic                  last;
    } pool_result_t;

    // shadow copy of the pool
    logic [POINT_BITS-1:0] slot_point [POOL_DEPTH];
    logic [DIST_W-1:0]     slot_dist  [POOL_DEPTH];
    logic                  slot_seen  [POOL_DEPTH];
    int unsigned           fill;
    logic [CFG_W-1:0]      limit_reg;
    logic [CFG_W-1:0]      count_reg;

    pool_result_t          due_results [$];
    pool_result_t          head;
    int                    err_cnt = 0;

    function automatic int unsigned clamp_to_depth(input logic [CFG_W-1:0] v);
        if (v == '0)
            return 1;
        if (v > POOL_DEPTH)
            return POOL_DEPTH;
        return v;
    endfunction

    // order is (distance, point) ascending
    function automatic bit key_below(input logic [DIST_W-1:0] da,
                                     input logic [POINT_BITS-1:0] pa,
                                     input logic [DIST_W-1:0] db,
                                     input logic [POINT_BITS-1:0] pb);
        if (da != db)
            return da < db;
        return pa < pb;
    endfunction

    function automatic void compare_field(input string name, input logic [31:0] want,
                                          input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            err_cnt++;
        end
    endfunction

    // appends one predicted result at the tail
    function automatic void enqueue_result(input pool_result_t r);
        due_results = {due_results, r};
    endfunction

    // updates the shadow pool and queues the results of one request
    function automatic void pool_update(input kind_t k, input logic [POINT_BITS-1:0] pt,
                                        input logic [DIST_W-1:0] d);
        int unsigned           lim;
        int unsigned           n;
        int                    pos;
        bit                    ok;
        bit                    found;
        logic [POINT_BITS-1:0] tp;
        logic [DIST_W-1:0]     td;
        logic                  tc;
        pool_result_t          r;
        r.kind     = k;
        r.point    = '0;
        r.distance = '0;
        r.hit      = 1'b0;
        r.last     = 1'b1;
        case (k)
            KIND_CLEAR:
            begin
                for (int i = 0; i < POOL_DEPTH; i++)
                begin
                    slot_point[i] = '0;
                    slot_dist[i]  = '0;
                    slot_seen[i]  = 1'b0;
                end
                fill = 0;
                enqueue_result(r);
            end
            KIND_INSERT:
            begin
                lim = clamp_to_depth(limit_reg);
                ok  = 1'b1;
                if (fill >= lim)
                begin
                    // full (or limit lowered under the fill): fight the last entry
                    pos = fill - 1;
                    ok  = key_below(d, pt, slot_dist[pos], slot_point[pos]);
                end
                else
                begin
                    pos = fill;
                    fill++;
                end
                if (ok)
                begin
                    slot_point[pos] = pt;
                    slot_dist[pos]  = d;
                    slot_seen[pos]  = 1'b0;
                    while (pos > 0 && key_below(slot_dist[pos], slot_point[pos],
                                                slot_dist[pos-1], slot_point[pos-1]))
                    begin
                        tp = slot_point[pos]; slot_point[pos] = slot_point[pos-1];
                        slot_point[pos-1] = tp;
                        td = slot_dist[pos]; slot_dist[pos] = slot_dist[pos-1];
                        slot_dist[pos-1] = td;
                        tc = slot_seen[pos]; slot_seen[pos] = slot_seen[pos-1];
                        slot_seen[pos-1] = tc;
                        pos--;
                    end
                end
                r.hit = ok;
                enqueue_result(r);
            end
            KIND_TAKE:
            begin
                found = 1'b0;
                for (int i = 0; i < fill && !found; i++)
                begin
                    if (!slot_seen[i])
                    begin
                        slot_seen[i] = 1'b1;
                        r.point      = slot_point[i];
                        r.distance   = slot_dist[i];
                        r.hit        = 1'b1;
                        found        = 1'b1;
                    end
                end
                enqueue_result(r);
            end
            KIND_READ:
            begin
                n = clamp_to_depth(count_reg);
                for (int i = 0; i < n; i++)
                begin
                    r.last = (i == n - 1);
                    if (i < fill)
                    begin
                        r.point    = slot_point[i];
                        r.distance = slot_dist[i];
                        r.hit      = 1'b1;
                    end
                    else
                    begin
                        r.point    = '0;
                        r.distance = '0;
                        r.hit      = 1'b0;
                    end
                    enqueue_result(r);
                end
            end
            default: ;
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < POOL_DEPTH; i++)
            begin
                slot_point[i] = '0;
                slot_dist[i]  = '0;
                slot_seen[i]  = 1'b0;
            end
            fill      = 0;
            limit_reg = POOL_LIMIT_RST;
            count_reg = RESULT_COUNT_RST;
            due_results.delete();
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (due_results.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual kind %0h data %0h",
                             $time, m_tuser[KIND_W-1:0], m_tdata);
                    err_cnt++;
                end
                else
                begin
                    head = due_results.pop_front();
                    compare_field("echo_kind", head.kind, m_tuser[KIND_W-1:0]);
                    compare_field("entry_point", head.point, m_tdata[POINT_BITS-1:0]);
                    compare_field("entry_distance", head.distance,
                                  m_tdata[POINT_BITS +: DIST_W]);
                    compare_field("hit", head.hit, m_tuser[KIND_W]);
                    compare_field("last_of_run", head.last, m_tlast);
                end
            end
            if (cfg_we)
            begin
                if (cfg_addr == REG_POOL_LIMIT)
                    limit_reg = cfg_wdata;
                else
                    count_reg = cfg_wdata;
            end
            if (s_tvalid && s_tready)
                pool_update(kind_t'(s_tuser), s_tdata[POINT_BITS-1:0],
                            s_tdata[POINT_BITS +: DIST_W]);
        end
        // published after the edge so the stimulus side reads a settled value
        outstanding <= due_results.size();
        mismatches  <= err_cnt;
    end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// Top of the candidate pool testbench: clock, reset, request stimulus,
// config writes, result back-pressure and the verdict. Uses bscp_pkg, bscp_scoreboard.
module tb;
    import bscp_pkg::*;

    localparam int POINT_BITS     = DEF_POINT_BITS;
    localparam int TDATA_W        = ((POINT_BITS + DIST_W + 7) / 8) * 8;
    // longest quiet stretch tolerated
    localparam int WATCHDOG_LIMIT = 2000;
    // worst readout gives 64 ranks
    localparam int TAIL_CYCLES    = 80;

    logic                clk;
    logic                rst_n    = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [TDATA_W-1:0]  s_tdata  = '0;     // cand_point, cand_distance, zero pad
    logic [KIND_W-1:0]   s_tuser  = KIND_CLEAR; // kind
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [TDATA_W-1:0]  m_tdata;           // entry_point, entry_distance, zero pad
    logic [KIND_W:0]     m_tuser;           // echo_kind, hit
    logic                m_tlast;           // last_of_run
    logic                cfg_we    = 1'b0;
    cfg_reg_t            cfg_addr  = REG_POOL_LIMIT;
    logic [CFG_W-1:0]    cfg_wdata = '0;

    int                  outstanding;
    int                  mismatches;
    int                  src_idle_pct   = 0;
    int                  sink_stall_pct = 0;
    int                  quiet_cycles   = 0;

    beam_search_candidate_pool uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    bscp_scoreboard chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .outstanding (outstanding),
        .mismatches  (mismatches)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // result side back-pressure, rate set per phase
    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= sink_stall_pct);

    // watchdog: any accepted request or result restarts the count
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // Present one request and hold it until accepted. tvalid stays high
    // into the next request unless a random gap is drawn.
    task automatic offer_request(input kind_t k, input logic [POINT_BITS-1:0] pt,
                                 input logic [DIST_W-1:0] d);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= k;
        s_tdata  <= TDATA_W'({d, pt});
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // Stop sending and wait for every predicted result; the pool is idle
    // once the last result is out, and the wait after that is margin.
    task automatic drain_pool();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Both registers written back to back while the pool is idle.
    task automatic retune_pool(input logic [CFG_W-1:0] limit, input logic [CFG_W-1:0] count);
        drain_pool();
        cfg_we    <= 1'b1;
        cfg_addr  <= REG_POOL_LIMIT;
        cfg_wdata <= limit;
        @(posedge clk);
        cfg_addr  <= REG_RESULT_COUNT;
        cfg_wdata <= count;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    // Random queries: mostly clear, a run of inserts, takes and occasional readouts,
    // then a readout; some queries skip the clear so pools carry over.
    task automatic run_queries(input int budget);
        int                    sent;
        int                    steps;
        int                    pick;
        logic [POINT_BITS-1:0] pt;
        logic [DIST_W-1:0]     d;
        sent = 0;
        while (sent < budget)
        begin
            if ($urandom_range(9) != 0)
            begin
                offer_request(KIND_CLEAR, POINT_BITS'($urandom), $urandom);
                sent++;
            end
            steps = $urandom_range(3, 10);
            for (int i = 0; i < steps; i++)
            begin
                pick = $urandom_range(99);
                // small ranges give ties and repeats, full range hits every bit
                pt = $urandom_range(1) ? POINT_BITS'($urandom_range(0, 63)) : POINT_BITS'($urandom);
                d  = ($urandom_range(3) == 0) ? $urandom : DIST_W'($urandom_range(0, 40));
                if (pick < 65)
                    offer_request(KIND_INSERT, pt, d);
                else if (pick < 92)
                    offer_request(KIND_TAKE, pt, d);
                else
                    offer_request(KIND_READ, pt, d);
            end
            offer_request(KIND_READ, POINT_BITS'($urandom), $urandom);
            sent += steps + 1;
        end
    endtask

    initial
    begin
        int               src_pct  [4];
        int               sink_pct [4];
        logic [CFG_W-1:0] lim;
        logic [CFG_W-1:0] cnt;
        src_pct  = '{0, 76, 0, 23};
        sink_pct = '{0, 0, 76, 23};

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed part, reset config: limit 64, count 10 ---
        // empty pool: every rank misses, take finds nothing
        offer_request(KIND_READ, '0, '0);
        offer_request(KIND_TAKE, '0, '0);
        // field extremes, a distance tie, an infinity pattern
        offer_request(KIND_INSERT, 24'hFFFFFF, 32'hFFFFFFFF);
        offer_request(KIND_INSERT, 24'h000000, 32'h00000000);
        offer_request(KIND_INSERT, 24'd7, 32'd100);
        offer_request(KIND_INSERT, 24'd3, 32'd100);
        offer_request(KIND_INSERT, 24'hAAAAAA, 32'h7F800000);
        offer_request(KIND_TAKE, '0, '0);
        offer_request(KIND_TAKE, '0, '0);
        // ranks past the fill come back empty
        offer_request(KIND_READ, '0, '0);
        offer_request(KIND_CLEAR, 24'h555555, 32'h55555555);

        // tiny pool: full-pool replace rules, take after all are checked
        retune_pool(7'd2, 7'd1);
        offer_request(KIND_INSERT, 24'd10, 32'd50);
        offer_request(KIND_INSERT, 24'd11, 32'd60);
        offer_request(KIND_INSERT, 24'd12, 32'd70);   // worse: rejected
        offer_request(KIND_INSERT, 24'd11, 32'd60);   // equal key: rejected
        offer_request(KIND_INSERT, 24'd9, 32'd60);    // tie, lower point: replaces
        offer_request(KIND_TAKE, '0, '0);
        offer_request(KIND_TAKE, '0, '0);
        offer_request(KIND_TAKE, '0, '0);             // nothing unchecked left
        offer_request(KIND_READ, '0, '0);

        // count of zero acts as one; grow the fill to five
        retune_pool(7'd64, 7'd0);
        offer_request(KIND_INSERT, 24'd20, 32'd5);
        offer_request(KIND_INSERT, 24'd21, 32'd6);
        offer_request(KIND_INSERT, 24'd22, 32'd7);
        offer_request(KIND_READ, '0, '0);

        // limit of zero acts as one, now under the fill: the pool counts as
        // full and inserts compete with the last filled entry; count clamps to 64
        retune_pool(7'd0, 7'd127);
        offer_request(KIND_INSERT, 24'd30, 32'd1000);
        offer_request(KIND_INSERT, 24'd23, 32'd8);
        offer_request(KIND_READ, '0, '0);

        // --- random part: four idling phases, two settings each ---
        for (int ph = 0; ph < 4; ph++)
        begin
            for (int sub = 0; sub < 2; sub++)
            begin
                lim = CFG_W'($urandom_range(1, 12));
                cnt = CFG_W'($urandom_range(1, 12));
                case (ph * 2 + sub)
                    0:
                    begin
                        lim = 7'd64;
                        cnt = 7'd64;
                    end
                    3:
                    begin
                        lim = 7'd127;
                        cnt = 7'd0;
                    end
                    5:
                    begin
                        lim = 7'd1;
                        cnt = 7'd127;
                    end
                    default: ;
                endcase
                retune_pool(lim, cnt);
                src_idle_pct   = src_pct[ph];
                sink_stall_pct = sink_pct[ph];
                run_queries(18);
            end
        end

        drain_pool();
        sink_stall_pct = 0;
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/bscp_pkg.sv
rtl/bscp_cell.sv
rtl/beam_search_candidate_pool.sv
rtl/bscp_checker.sv
tb/bscp_checker.sv
tb/tb.sv
